// File: src/ipsp_pkg.sv
// ----------------------------------------------------------------------------
// IPS patch parser package
// Shared transaction types, parse phases, event and cause codes, header magic.
// ----------------------------------------------------------------------------
package ipsp_pkg;

   // Patch byte limits and markers
   localparam logic [24:0] MAX_PATCH_BYTES = 25'd16777216;
   localparam logic [24:0] MIN_PATCH_BYTES = 25'd9;
   localparam logic [24:0] DEST_SIZE_RESET = 25'h1000000;
   localparam logic [23:0] EOF_MARK        = 24'h454F46;
   localparam logic [2:0]  HDR_LAST_IDX    = 3'd4;

   // Result event codes
   localparam logic [1:0] EV_RUN  = 2'd0;
   localparam logic [1:0] EV_OK   = 2'd1;
   localparam logic [1:0] EV_FAIL = 2'd2;

   // Failure causes
   localparam logic [2:0] CAUSE_NONE  = 3'd0;
   localparam logic [2:0] CAUSE_HDR   = 3'd1;
   localparam logic [2:0] CAUSE_SHORT = 3'd2;
   localparam logic [2:0] CAUSE_LONG  = 3'd3;
   localparam logic [2:0] CAUSE_OVF   = 3'd4;
   localparam logic [2:0] CAUSE_TRUNC = 3'd5;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_OFS0,
      PH_OFS1,
      PH_OFS2,
      PH_SZ0,
      PH_SZ1,
      PH_RL0,
      PH_RL1,
      PH_RV,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [23:0] write_address;
      logic [7:0]  write_value;
      logic [15:0] run_length;
      logic [2:0]  error_cause;
   } rsp_type;

   // Classified work for one patch byte: an optional run and an optional end event
   typedef struct packed {
      logic        run_valid;
      logic [23:0] run_address;
      logic [7:0]  run_value;
      logic [15:0] run_length;
      logic        fin_valid;
      logic [1:0]  fin_event;
      logic [2:0]  fin_cause;
   } cmd_type;

   // Expected header byte ("PATCH") at a given position
   function automatic logic [7:0] hdr_magic(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h50;
         3'd1:    val = 8'h41;
         3'd2:    val = 8'h54;
         3'd3:    val = 8'h43;
         3'd4:    val = 8'h48;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: src/ipsp_front.sv
// ----------------------------------------------------------------------------
// IPS patch parser front end
// Accepts patch bytes, tracks the record fields and classifies each byte into
// a command holding an optional write run and an optional end event.
// ----------------------------------------------------------------------------
module ipsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [24:0]      csr_data,
   input  logic             req_valid,
   input  ipsp_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output ipsp_pkg::cmd_type q_cmd
);

   ipsp_pkg::phase_type phase_ff, phase_in, ph_step;
   logic [24:0] seen_ff, seen_in, seen_next;
   logic [23:0] field_ff, field_in, field_step;
   logic [24:0] ra_ff, ra_in, ra_step;
   logic [15:0] rem_ff, rem_in, rem_step;
   logic        halted_ff, halted_in;
   logic [24:0] ds_ff;

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic        short_hit, long_hit;
   logic        ra_ovf, ra_step_ovf, avail_lt_rem;
   logic [24:0] avail;
   logic [15:0] run_len;
   logic [23:0] field_cat;
   logic [15:0] size_cat;
   logic [2:0]  hdr_idx;
   logic        pfin, run_v, fin;
   logic [1:0]  pev, fev;
   logic [2:0]  pcause, fcause;
   logic [15:0] run_l;

   assign accept = req_valid && !q_full;
   assign b      = req_data.patch_byte;
   assign last   = req_data.last_byte;

   // Shared compares and field assembly
   always_comb begin
      seen_next    = (seen_ff <= ipsp_pkg::MAX_PATCH_BYTES) ? seen_ff + 25'd1 : seen_ff;
      short_hit    = last && (seen_next < ipsp_pkg::MIN_PATCH_BYTES);
      long_hit     = seen_next > ipsp_pkg::MAX_PATCH_BYTES;
      ra_ovf       = ra_ff >= ds_ff;
      avail        = ds_ff - ra_ff;
      avail_lt_rem = avail < {9'd0, rem_ff};
      run_len      = avail_lt_rem ? avail[15:0] : rem_ff;
      field_cat    = {field_ff[15:0], b};
      size_cat     = {rem_ff[7:0], b};
      hdr_idx      = seen_next[2:0] - 3'd1;
   end

   // Parse one byte against the current phase
   always_comb begin
      ph_step    = phase_ff;
      field_step = field_ff;
      ra_step    = ra_ff;
      rem_step   = rem_ff;
      pfin       = 1'b0;
      pev        = ipsp_pkg::EV_OK;
      pcause     = ipsp_pkg::CAUSE_NONE;
      run_v      = 1'b0;
      run_l      = run_len;
      case (phase_ff)
         ipsp_pkg::PH_HDR: begin
            if (hdr_idx > ipsp_pkg::HDR_LAST_IDX || b != ipsp_pkg::hdr_magic(hdr_idx)) begin
               pfin   = 1'b1;
               pev    = ipsp_pkg::EV_FAIL;
               pcause = ipsp_pkg::CAUSE_HDR;
            end else if (hdr_idx == ipsp_pkg::HDR_LAST_IDX) begin
               ph_step = ipsp_pkg::PH_OFS0;
            end
         end
         ipsp_pkg::PH_OFS0: begin
            field_step = {16'd0, b};
            ph_step    = ipsp_pkg::PH_OFS1;
         end
         ipsp_pkg::PH_OFS1: begin
            field_step = field_cat;
            ph_step    = ipsp_pkg::PH_OFS2;
         end
         ipsp_pkg::PH_OFS2: begin
            field_step = field_cat;
            if (field_cat == ipsp_pkg::EOF_MARK) begin
               pfin = 1'b1;
            end else begin
               ra_step = {1'b0, field_cat};
               ph_step = ipsp_pkg::PH_SZ0;
            end
         end
         ipsp_pkg::PH_SZ0: begin
            rem_step = {8'd0, b};
            ph_step  = ipsp_pkg::PH_SZ1;
         end
         ipsp_pkg::PH_SZ1: begin
            rem_step = size_cat;
            ph_step  = (size_cat != 16'd0) ? ipsp_pkg::PH_DATA : ipsp_pkg::PH_RL0;
         end
         ipsp_pkg::PH_RL0: begin
            rem_step = {8'd0, b};
            ph_step  = ipsp_pkg::PH_RL1;
         end
         ipsp_pkg::PH_RL1: begin
            rem_step = size_cat;
            ph_step  = ipsp_pkg::PH_RV;
         end
         ipsp_pkg::PH_RV: begin
            if (last) begin
               // a final fill value byte emits no run
               pfin = 1'b1;
               if (rem_ff != 16'd0) begin
                  pev    = ipsp_pkg::EV_FAIL;
                  pcause = ra_ovf ? ipsp_pkg::CAUSE_OVF : ipsp_pkg::CAUSE_TRUNC;
               end
            end else begin
               if (rem_ff != 16'd0) begin
                  if (ra_ovf) begin
                     pfin   = 1'b1;
                     pev    = ipsp_pkg::EV_FAIL;
                     pcause = ipsp_pkg::CAUSE_OVF;
                  end else begin
                     run_v = 1'b1;
                     if (avail_lt_rem) begin
                        pfin   = 1'b1;
                        pev    = ipsp_pkg::EV_FAIL;
                        pcause = ipsp_pkg::CAUSE_OVF;
                     end
                  end
               end
               ph_step = ipsp_pkg::PH_OFS0;
            end
         end
         ipsp_pkg::PH_DATA: begin
            if (ra_ovf) begin
               pfin   = 1'b1;
               pev    = ipsp_pkg::EV_FAIL;
               pcause = ipsp_pkg::CAUSE_OVF;
            end else begin
               run_v    = 1'b1;
               run_l    = 16'd1;
               ra_step  = ra_ff + 25'd1;
               rem_step = rem_ff - 16'd1;
               if (rem_ff == 16'd1) begin
                  ph_step = ipsp_pkg::PH_OFS0;
               end
            end
         end
         default: begin
            ph_step = ipsp_pkg::PH_OFS0;
         end
      endcase
   end

   assign ra_step_ovf = ra_step >= ds_ff;

   // Settle the end event: length limits first, then parse, then end of stream
   always_comb begin
      fin    = 1'b0;
      fev    = ipsp_pkg::EV_OK;
      fcause = ipsp_pkg::CAUSE_NONE;
      if (halted_ff) begin
         fin = 1'b0;
      end else if (short_hit) begin
         fin    = 1'b1;
         fev    = ipsp_pkg::EV_FAIL;
         fcause = ipsp_pkg::CAUSE_SHORT;
      end else if (long_hit) begin
         fin    = 1'b1;
         fev    = ipsp_pkg::EV_FAIL;
         fcause = ipsp_pkg::CAUSE_LONG;
      end else if (pfin) begin
         fin    = 1'b1;
         fev    = pev;
         fcause = pcause;
      end else if (last) begin
         fin = 1'b1;
         if (ph_step == ipsp_pkg::PH_DATA ||
             (ph_step == ipsp_pkg::PH_RV && rem_step != 16'd0)) begin
            fev    = ipsp_pkg::EV_FAIL;
            fcause = ra_step_ovf ? ipsp_pkg::CAUSE_OVF : ipsp_pkg::CAUSE_TRUNC;
         end else if (ph_step == ipsp_pkg::PH_HDR) begin
            fev    = ipsp_pkg::EV_FAIL;
            fcause = ipsp_pkg::CAUSE_SHORT;
         end
      end
   end

   // Build the command for the queue
   always_comb begin
      q_cmd.run_valid   = run_v && !halted_ff && !short_hit && !long_hit;
      q_cmd.run_address = ra_ff[23:0];
      q_cmd.run_value   = b;
      q_cmd.run_length  = run_l;
      q_cmd.fin_valid   = fin;
      q_cmd.fin_event   = fev;
      q_cmd.fin_cause   = fcause;
      q_push            = accept && (q_cmd.run_valid || q_cmd.fin_valid);
   end

   // Next parser state: rearm on the marked byte, freeze while halted
   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      field_in  = field_ff;
      ra_in     = ra_ff;
      rem_in    = rem_ff;
      halted_in = halted_ff;
      if (accept) begin
         if (last) begin
            phase_in  = ipsp_pkg::PH_HDR;
            seen_in   = '0;
            field_in  = '0;
            ra_in     = '0;
            rem_in    = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            phase_in  = ph_step;
            seen_in   = seen_next;
            field_in  = field_step;
            ra_in     = ra_step;
            rem_in    = rem_step;
            halted_in = fin;
         end
      end
   end

   // Hold parser state and the destination size register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ipsp_pkg::PH_HDR;
         seen_ff   <= '0;
         field_ff  <= '0;
         ra_ff     <= '0;
         rem_ff    <= '0;
         halted_ff <= 1'b0;
         ds_ff     <= ipsp_pkg::DEST_SIZE_RESET;
      end else begin
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
         field_ff  <= field_in;
         ra_ff     <= ra_in;
         rem_ff    <= rem_in;
         halted_ff <= halted_in;
         if (csr_valid) begin
            ds_ff <= csr_data;
         end
      end
   end

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (phase_ff == ipsp_pkg::PH_HDR && !halted_ff && seen_ff == '0))
      else $error("marked byte did not rearm the parser");

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && accept) |-> !q_push)
      else $error("halted parser produced a transaction");

endmodule

// File: src/ipsp_queue.sv
// ----------------------------------------------------------------------------
// IPS patch parser command queue
// Short first-word-fall-through queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module ipsp_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipsp_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output ipsp_pkg::cmd_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ipsp_pkg::cmd_type store [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = store[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from an empty queue");

endmodule

// File: src/ipsp_back.sv
// ----------------------------------------------------------------------------
// IPS patch parser result emitter
// Takes commands from the queue and sends their run and end event, one result
// transaction per cycle while rsp_ready allows, through an output register.
// ----------------------------------------------------------------------------
module ipsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ipsp_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipsp_pkg::rsp_type rsp_data
);

   ipsp_pkg::cmd_type cur_ff, cur_in;
   logic pend_run_ff, pend_run_in;
   logic pend_fin_ff, pend_fin_in;
   logic rsp_valid_ff, rsp_valid_in;
   ipsp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic out_free, has_pend, emit, slot_free;

   // Decide emit and pop
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      has_pend  = pend_run_ff || pend_fin_ff;
      emit      = has_pend && out_free;
      slot_free = !has_pend || (emit && (pend_run_ff ^ pend_fin_ff));
      cmd_pop   = cmd_valid && slot_free;
   end

   // Next pending command
   always_comb begin
      cur_in      = cur_ff;
      pend_run_in = pend_run_ff;
      pend_fin_in = pend_fin_ff;
      if (cmd_pop) begin
         cur_in      = cmd_data;
         pend_run_in = cmd_data.run_valid;
         pend_fin_in = cmd_data.fin_valid;
      end else if (emit) begin
         if (pend_run_ff) begin
            pend_run_in = 1'b0;
         end else begin
            pend_fin_in = 1'b0;
         end
      end
   end

   // Next output register: run first, then the end event
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (pend_run_ff) begin
            rsp_data_in.event_res     = ipsp_pkg::EV_RUN;
            rsp_data_in.write_address = cur_ff.run_address;
            rsp_data_in.write_value   = cur_ff.run_value;
            rsp_data_in.run_length    = cur_ff.run_length;
            rsp_data_in.error_cause   = ipsp_pkg::CAUSE_NONE;
         end else begin
            rsp_data_in.event_res     = cur_ff.fin_event;
            rsp_data_in.write_address = '0;
            rsp_data_in.write_value   = '0;
            rsp_data_in.run_length    = '0;
            rsp_data_in.error_cause   = cur_ff.fin_cause;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_run_ff  <= 1'b0;
         pend_fin_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_run_ff  <= pend_run_in;
         pend_fin_ff  <= pend_fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_loads_work: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (pend_run_ff || pend_fin_ff))
      else $error("queue popped an empty command");

endmodule

// File: src/ips_patch_stream_parser_top.sv
// Path: a command is registered in the queue, the pending register and the output
// register in turn; a byte that causes a run and an end event gives the run first.
// Throughput: one patch byte per cycle while the command queue (QUEUE_DEPTH entries)
// has room, one result transaction per cycle on rsp while rsp_ready is high.
// Reset: synchronous, clears the parser to header phase, sets dest_size to 16777216
// and empties the queue and output register.
// ----------------------------------------------------------------------------
// IPS patch stream parser
// Parses an IPS patch byte stream into write runs and one end event per patch.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [24:0]       csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipsp_pkg::rsp_type rsp_data
);

   logic              q_full;
   logic              q_push;
   ipsp_pkg::cmd_type q_cmd;
   logic              q_pop;
   logic              q_valid;
   ipsp_pkg::cmd_type q_head;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   ipsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   ipsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_head)
   );

   ipsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/ips_patch_stream_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPS patch parser result checker
// Watches the csr, req and rsp channels, parses every accepted patch byte on
// its own copy of the parser state and compares each result transaction,
// field by field, with the oldest predicted event.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [24:0]       csr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ipsp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ipsp_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                events_checked
);

   // "PATCH", first character in the top byte
   localparam logic [39:0] HEADER_TAG = 40'h5041544348;

   // Parser state mirrored from the block
   logic [24:0]         dest_size;
   ipsp_pkg::phase_type phase;
   logic [24:0]         bytes_seen;
   logic [23:0]         field_shift;
   logic [24:0]         record_address;
   logic [15:0]         remaining_count;
   logic                halted;

   ipsp_pkg::rsp_type upcoming_events[$];
   ipsp_pkg::rsp_type oldest_event;

   // Rearm for the next patch; dest_size is kept
   function automatic void clear_parser();
      phase           = ipsp_pkg::PH_HDR;
      bytes_seen      = '0;
      field_shift     = '0;
      record_address  = '0;
      remaining_count = '0;
      halted          = 1'b0;
   endfunction

   function automatic void queue_event(input logic [1:0] ev, input logic [23:0] addr,
                                       input logic [7:0] value, input logic [15:0] len,
                                       input logic [2:0] cause);
      ipsp_pkg::rsp_type item;
      item.event_res     = ev;
      item.write_address = addr;
      item.write_value   = value;
      item.run_length    = len;
      item.error_cause   = cause;
      upcoming_events.push_back(item);
   endfunction

   // A patch cut off inside a record blames the destination if it already ran out
   function automatic logic [2:0] cut_cause();
      return (record_address >= dest_size) ? ipsp_pkg::CAUSE_OVF : ipsp_pkg::CAUSE_TRUNC;
   endfunction

   // Advance the parser by one patch byte and queue the events it causes
   function automatic void parse_byte(input ipsp_pkg::req_type item);
      logic [7:0]  b;
      logic        last;
      logic        fin;
      logic [1:0]  fin_event;
      logic [2:0]  fin_cause;
      logic [2:0]  hdr_idx;
      logic [24:0] room;
      logic [24:0] fill_len;
      b         = item.patch_byte;
      last      = item.last_byte;
      fin       = 1'b0;
      fin_event = ipsp_pkg::EV_OK;
      fin_cause = ipsp_pkg::CAUSE_NONE;

      // swallow everything after the end event until the marked byte
      if (halted) begin
         if (last) clear_parser();
         return;
      end
      if (bytes_seen <= ipsp_pkg::MAX_PATCH_BYTES) bytes_seen = bytes_seen + 25'd1;
      if (last && bytes_seen < ipsp_pkg::MIN_PATCH_BYTES) begin
         queue_event(ipsp_pkg::EV_FAIL, '0, '0, '0, ipsp_pkg::CAUSE_SHORT);
         clear_parser();
         return;
      end
      if (bytes_seen > ipsp_pkg::MAX_PATCH_BYTES) begin
         queue_event(ipsp_pkg::EV_FAIL, '0, '0, '0, ipsp_pkg::CAUSE_LONG);
         if (last) clear_parser();
         else halted = 1'b1;
         return;
      end

      case (phase)
         ipsp_pkg::PH_HDR: begin
            hdr_idx = bytes_seen[2:0] - 3'd1;
            if (hdr_idx > ipsp_pkg::HDR_LAST_IDX ||
                b != HEADER_TAG[8 * (4 - hdr_idx) +: 8]) begin
               fin       = 1'b1;
               fin_event = ipsp_pkg::EV_FAIL;
               fin_cause = ipsp_pkg::CAUSE_HDR;
            end else if (hdr_idx == ipsp_pkg::HDR_LAST_IDX) begin
               phase = ipsp_pkg::PH_OFS0;
            end
         end
         ipsp_pkg::PH_OFS0: begin
            field_shift = {16'd0, b};
            phase       = ipsp_pkg::PH_OFS1;
         end
         ipsp_pkg::PH_OFS1: begin
            field_shift = {field_shift[15:0], b};
            phase       = ipsp_pkg::PH_OFS2;
         end
         ipsp_pkg::PH_OFS2: begin
            field_shift = {field_shift[15:0], b};
            if (field_shift == ipsp_pkg::EOF_MARK) begin
               fin       = 1'b1;
               fin_event = ipsp_pkg::EV_OK;
            end else begin
               record_address = {1'b0, field_shift};
               phase          = ipsp_pkg::PH_SZ0;
            end
         end
         ipsp_pkg::PH_SZ0: begin
            remaining_count = {8'd0, b};
            phase           = ipsp_pkg::PH_SZ1;
         end
         ipsp_pkg::PH_SZ1: begin
            remaining_count = {remaining_count[7:0], b};
            if (remaining_count != 16'd0) phase = ipsp_pkg::PH_DATA;
            else phase = ipsp_pkg::PH_RL0;
         end
         ipsp_pkg::PH_RL0: begin
            remaining_count = {8'd0, b};
            phase           = ipsp_pkg::PH_RL1;
         end
         ipsp_pkg::PH_RL1: begin
            remaining_count = {remaining_count[7:0], b};
            phase           = ipsp_pkg::PH_RV;
         end
         ipsp_pkg::PH_RV: begin
            if (last) begin
               // a fill value on the final byte never emits its run
               fin = 1'b1;
               if (remaining_count != 16'd0) begin
                  fin_event = ipsp_pkg::EV_FAIL;
                  fin_cause = cut_cause();
               end else begin
                  fin_event = ipsp_pkg::EV_OK;
               end
            end else begin
               if (remaining_count != 16'd0) begin
                  if (record_address >= dest_size) begin
                     fin       = 1'b1;
                     fin_event = ipsp_pkg::EV_FAIL;
                     fin_cause = ipsp_pkg::CAUSE_OVF;
                  end else begin
                     // clip the fill at the end of the destination
                     room     = dest_size - record_address;
                     fill_len = ({9'd0, remaining_count} < room) ? {9'd0, remaining_count}
                                                                  : room;
                     queue_event(ipsp_pkg::EV_RUN, record_address[23:0], b, fill_len[15:0],
                                 ipsp_pkg::CAUSE_NONE);
                     if (fill_len < {9'd0, remaining_count}) begin
                        fin       = 1'b1;
                        fin_event = ipsp_pkg::EV_FAIL;
                        fin_cause = ipsp_pkg::CAUSE_OVF;
                     end
                  end
               end
               phase = ipsp_pkg::PH_OFS0;
            end
         end
         ipsp_pkg::PH_DATA: begin
            if (record_address >= dest_size) begin
               fin       = 1'b1;
               fin_event = ipsp_pkg::EV_FAIL;
               fin_cause = ipsp_pkg::CAUSE_OVF;
            end else begin
               queue_event(ipsp_pkg::EV_RUN, record_address[23:0], b, 16'd1,
                           ipsp_pkg::CAUSE_NONE);
               record_address  = record_address + 25'd1;
               remaining_count = remaining_count - 16'd1;
               if (remaining_count == 16'd0) phase = ipsp_pkg::PH_OFS0;
            end
         end
         default: phase = ipsp_pkg::PH_OFS0;
      endcase

      // the marked byte closes the patch wherever the parser stands
      if (!fin && last) begin
         fin = 1'b1;
         if (phase == ipsp_pkg::PH_DATA ||
             (phase == ipsp_pkg::PH_RV && remaining_count != 16'd0)) begin
            fin_event = ipsp_pkg::EV_FAIL;
            fin_cause = cut_cause();
         end else if (phase == ipsp_pkg::PH_HDR) begin
            fin_event = ipsp_pkg::EV_FAIL;
            fin_cause = ipsp_pkg::CAUSE_SHORT;
         end else begin
            fin_event = ipsp_pkg::EV_OK;
         end
      end

      if (fin) begin
         queue_event(fin_event, '0, '0, '0,
                     (fin_event == ipsp_pkg::EV_FAIL) ? fin_cause : ipsp_pkg::CAUSE_NONE);
         if (last) clear_parser();
         else halted = 1'b1;
      end
   endfunction

   // Compare results, take register writes, predict accepted bytes
   always @(posedge clock) begin
      if (reset) begin
         upcoming_events.delete();
         dest_size      = ipsp_pkg::DEST_SIZE_RESET;
         clear_parser();
         mismatch_count = 0;
         events_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (upcoming_events.size() == 0) begin
               $error("result transaction with none predicted: event_res %0d cause %0d",
                      rsp_data.event_res, rsp_data.error_cause);
               mismatch_count++;
            end else begin
               oldest_event = upcoming_events.pop_front();
               events_checked++;
               if (rsp_data.event_res !== oldest_event.event_res) begin
                  $error("event_res: expected %0d, actual %0d",
                         oldest_event.event_res, rsp_data.event_res);
                  mismatch_count++;
               end
               if (rsp_data.write_address !== oldest_event.write_address) begin
                  $error("write_address: expected 0x%06h, actual 0x%06h",
                         oldest_event.write_address, rsp_data.write_address);
                  mismatch_count++;
               end
               if (rsp_data.write_value !== oldest_event.write_value) begin
                  $error("write_value: expected 0x%02h, actual 0x%02h",
                         oldest_event.write_value, rsp_data.write_value);
                  mismatch_count++;
               end
               if (rsp_data.run_length !== oldest_event.run_length) begin
                  $error("run_length: expected %0d, actual %0d",
                         oldest_event.run_length, rsp_data.run_length);
                  mismatch_count++;
               end
               if (rsp_data.error_cause !== oldest_event.error_cause) begin
                  $error("error_cause: expected %0d, actual %0d",
                         oldest_event.error_cause, rsp_data.error_cause);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) dest_size = csr_data;
         if (req_valid && req_ready) parse_byte(req_data);
      end
      pending_count = upcoming_events.size();
   end

endmodule

// File: verif/ips_patch_stream_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPS patch stream parser testbench
// Streams directed and random IPS patches (clean, cut short, bad header,
// trailing junk, missing EOF, noise) through the parser over a range of
// dest_size settings, with random idling on both channels and one long
// result hold-off. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_top_tb;

   localparam int CLOCK_HALF_NS    = 4;
   localparam int RESET_CYCLES     = 5;
   localparam int SETTLE_CYCLES    = 10;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int BYTES_PER_PHASE  = 110;
   localparam int PHASE_COUNT      = 8;
   localparam int TIMEOUT_NS       = 4_000_000;

   typedef enum int {
      SHAPE_CLEAN,
      SHAPE_TRAILING,
      SHAPE_NO_EOF,
      SHAPE_CUT,
      SHAPE_SHORT,
      SHAPE_BAD_HEADER,
      SHAPE_NOISE
   } patch_shape_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [24:0]       csr_data;
   logic              req_valid;
   logic              req_ready;
   ipsp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ipsp_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int events_checked;

   logic        idle_on;
   logic        long_hold;
   logic        long_hold_done;
   logic [24:0] dest_setting;
   logic [24:0] dest_plan [0:PHASE_COUNT-1];
   logic [7:0]  patch_image[$];
   int          bytes_sent;
   int          patches_sent;
   int          settings_written;
   int          phase_goal;

   ips_patch_stream_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ips_patch_stream_parser_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .events_checked (events_checked)
   );

   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   // Bound the run
   initial begin
      #TIMEOUT_NS;
      $display("ips_patch_stream_parser_top_tb NOT OK");
      $finish;
   end

   // Drive rsp_ready: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ready      = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Append a big-endian field of nbytes bytes to the patch
   function automatic void add_field(input logic [23:0] value, input int nbytes);
      for (int k = nbytes - 1; k >= 0; k--) patch_image.push_back(value[8 * k +: 8]);
   endfunction

   // Bias record offsets toward the destination edge and the top of the space
   function automatic logic [23:0] pick_address();
      logic [24:0] base;
      case ($urandom_range(0, 3))
         0:       base = 25'($urandom_range(0, 63));
         1:       base = dest_setting - 25'd6 + 25'($urandom_range(0, 8));
         2:       base = 25'($urandom);
         default: base = 25'hFFFFFF - 25'($urandom_range(0, 6));
      endcase
      return base[23:0];
   endfunction

   // Append one literal or fill record
   function automatic void add_record();
      int unsigned len;
      int unsigned data_count;
      add_field(pick_address(), 3);
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 3))
            0:       len = 0;
            1:       len = 1;
            2:       len = 16'hFFFF;
            default: len = $urandom_range(0, 16'hFFFF);
         endcase
         add_field(24'd0, 2);
         add_field(24'(len), 2);
         patch_image.push_back(8'($urandom_range(0, 255)));
      end else begin
         // a huge size with few data bytes leaves the parser misaligned
         if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 16'hFFFF);
         else len = $urandom_range(1, 6);
         data_count = (len > 6) ? $urandom_range(1, 4) : len;
         add_field(24'(len), 2);
         repeat (data_count) patch_image.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_patch(input patch_shape_type shape);
      int unsigned cut;
      int unsigned pos;
      patch_image.delete();
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(1, 12)) patch_image.push_back(8'($urandom_range(0, 255)));
         return;
      end
      // "PATCH"
      add_field(24'h504154, 3);
      add_field(24'h4348, 2);
      if (shape == SHAPE_BAD_HEADER) begin
         pos = $urandom_range(0, 4);
         patch_image[pos] = patch_image[pos] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 4)) add_record();
      if (shape != SHAPE_NO_EOF) add_field(ipsp_pkg::EOF_MARK, 3);
      if (shape == SHAPE_TRAILING)
         repeat ($urandom_range(1, 4)) patch_image.push_back(8'($urandom_range(0, 255)));
      cut = patch_image.size();
      if (shape == SHAPE_CUT && patch_image.size() > 9)
         cut = $urandom_range(9, patch_image.size() - 1);
      if (shape == SHAPE_SHORT) cut = $urandom_range(1, 8);
      while (patch_image.size() > cut) void'(patch_image.pop_back());
   endfunction

   // Offer one patch byte, with an optional gap before it
   task automatic send_byte(input logic [7:0] value, input logic last);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.patch_byte <= value;
      req_data.last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_patch();
      for (int i = 0; i < patch_image.size(); i++)
         send_byte(patch_image[i], i == patch_image.size() - 1);
      patches_sent++;
   endtask

   // Hold the sender until every predicted result has come out
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_dest_size(input logic [24:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid    <= 1'b0;
      dest_setting  = value;
      settings_written++;
   endtask

   initial begin
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_data         = '0;
      idle_on          = 1'b1;
      long_hold        = 1'b0;
      bytes_sent       = 0;
      patches_sent     = 0;
      settings_written = 0;
      dest_setting     = ipsp_pkg::DEST_SIZE_RESET;
      dest_plan        = '{25'd300, 25'd1, 25'd0, 25'h1FFFFFF, 25'hFFFFFF,
                           25'h1000000, 25'd0, 25'd40};
      dest_plan[6]     = 25'($urandom_range(2, 24'hFFFFFF));
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Literal at address zero, then a full-length fill whose value is the final byte
      patch_image.delete();
      add_field(24'h504154, 3);
      add_field(24'h4348, 2);
      add_field(24'd0, 3);
      add_field(24'd1, 2);
      add_field(24'h00, 1);
      add_field(24'hFFFFFF, 3);
      add_field(24'd0, 2);
      add_field(24'hFFFF, 2);
      add_field(24'hFF, 1);
      send_patch();
      // Marked byte arrives in the header: too short
      patch_image.delete();
      add_field(24'h5041, 2);
      send_patch();
      // Wrong first header byte, rest swallowed up to the mark
      patch_image.delete();
      add_field(24'h0041, 2);
      send_patch();

      // Stall the results while a long literal record streams in
      patch_image.delete();
      add_field(24'h504154, 3);
      add_field(24'h4348, 2);
      add_field(24'd0, 3);
      add_field(24'd12, 2);
      repeat (12) patch_image.push_back(8'($urandom_range(0, 255)));
      add_field(ipsp_pkg::EOF_MARK, 3);
      long_hold = 1'b1;
      send_patch();
      wait_drain();

      // Random patches over a series of destination sizes; the last phase runs flat out
      for (int step = 0; step < PHASE_COUNT; step++) begin
         set_dest_size(dest_plan[step]);
         if (step == PHASE_COUNT - 1) idle_on = 1'b0;
         phase_goal = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < phase_goal) begin
            case ($urandom_range(0, 19))
               10, 11:     build_patch(SHAPE_TRAILING);
               12, 13:     build_patch(SHAPE_NO_EOF);
               14, 15, 16: build_patch(SHAPE_CUT);
               17:         build_patch(SHAPE_SHORT);
               18:         build_patch(SHAPE_BAD_HEADER);
               19:         build_patch(SHAPE_NOISE);
               default:    build_patch(SHAPE_CLEAN);
            endcase
            send_patch();
         end
      end

      wait_drain();
      $display("Streamed %0d patch bytes in %0d patches over %0d dest_size settings;",
               bytes_sent, patches_sent, settings_written);
      $display("checked %0d result transactions, %0d mismatches.",
               events_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ips_patch_stream_parser_top_tb OK");
      end else begin
         $display("ips_patch_stream_parser_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: ips_patch_stream_parser_top.f
src/ipsp_pkg.sv
src/ipsp_front.sv
src/ipsp_queue.sv
src/ipsp_back.sv
src/ips_patch_stream_parser_top.sv
verif/ips_patch_stream_parser_checker.sv
verif/ips_patch_stream_parser_top_tb.sv
